>>> design/hrd_pkg.sv
package hrd_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int STAMP_BITS = 32;
  localparam int CFG_BITS = 16;
  localparam int RATE_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;

  // divider works on the width of the dividend, one quotient bit a step
  localparam int DIV_BITS = 16;
  localparam int DIV_STEPS = DIV_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  localparam logic [DIV_BITS-1:0] RATE_NUMERATOR = DIV_BITS'(60000);
  localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

  localparam logic [CFG_BITS-1:0] RISE_RESET = CFG_BITS'(2200);
  localparam logic [CFG_BITS-1:0] FALL_RESET = CFG_BITS'(2000);
  localparam logic [CFG_BITS-1:0] MIN_RESET = CFG_BITS'(260);
  localparam logic [CFG_BITS-1:0] MAX_RESET = CFG_BITS'(1714);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RISE_THRESHOLD,
    CFG_FALL_THRESHOLD,
    CFG_MIN_INTERVAL,
    CFG_MAX_INTERVAL
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_mv;
    logic [STAMP_BITS-1:0]  time_ms;
  } sample_t;

  typedef struct packed {
    logic [RATE_BITS-1:0] rate_bpm;
    logic                 beat_seen;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fire_divide;
    logic out_free;
  } status_t;

endpackage

>>> design/hrd_ctrl.sv
module hrd_ctrl import hrd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t                state;
  state_t                state_next;
  logic [STEP_BITS-1:0]  step;
  logic [STEP_BITS-1:0]  step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    sample_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        sample_stall = !status.out_free;
        cmd.accept   = sample_valid && status.out_free;
        if (cmd.accept && status.fire_divide) begin
          cmd.start_div = 1'b1;
          step_next     = '0;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_BITS'(1);
        if (step == STEP_BITS'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/hrd_datapath.sv
module hrd_datapath import hrd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  sample_t                   sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  cmd_t                      cmd,
  output status_t                   status
);

  logic [CFG_BITS-1:0]  rise_threshold;
  logic [CFG_BITS-1:0]  fall_threshold;
  logic [CFG_BITS-1:0]  min_interval;
  logic [CFG_BITS-1:0]  max_interval;

  logic [TIME_BITS-1:0] last_beat_time;
  logic                 above_flag;
  logic [RATE_BITS-1:0] held_rate;

  logic [DIV_BITS-1:0]  divisor;
  logic [DIV_BITS-1:0]  rem;
  logic [DIV_BITS-1:0]  quo;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] interval;
  logic                 fire;
  logic                 in_range;
  logic                 direct_load;
  logic [DIV_BITS:0]    shifted;
  logic [DIV_BITS:0]    diff;
  logic [RATE_BITS-1:0] div_rate;

  if (TIME_BITS <= STAMP_BITS) begin : g_now_narrow
    assign now = sample.time_ms[TIME_BITS-1:0];
  end else begin : g_now_wide
    assign now = {{(TIME_BITS - STAMP_BITS){1'b0}}, sample.time_ms};
  end

  assign interval = now - last_beat_time;
  assign fire     = (sample.sample_mv > rise_threshold) && !above_flag;
  assign in_range = (interval > TIME_BITS'(min_interval))
                 && (interval < TIME_BITS'(max_interval));

  assign status.fire_divide = fire && in_range;
  assign status.out_free    = !result_valid || !result_stall;

  assign direct_load = cmd.accept && !cmd.start_div;

  assign shifted  = {rem, quo[DIV_BITS-1]};
  assign diff     = shifted - {1'b0, divisor};
  assign div_rate = (|quo[DIV_BITS-1:RATE_BITS]) ? RATE_MAX : quo[RATE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_threshold <= RISE_RESET;
      fall_threshold <= FALL_RESET;
      min_interval   <= MIN_RESET;
      max_interval   <= MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RISE_THRESHOLD: rise_threshold <= cfg_data;
        CFG_FALL_THRESHOLD: fall_threshold <= cfg_data;
        CFG_MIN_INTERVAL:   min_interval   <= cfg_data;
        CFG_MAX_INTERVAL:   max_interval   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_beat_time <= '0;
      above_flag     <= 1'b0;
      held_rate      <= '0;
    end else if (cmd.accept) begin
      if (fire) begin
        above_flag     <= 1'b1;
        last_beat_time <= now;
        if (!in_range) begin
          held_rate <= '0;
        end
      end else if (sample.sample_mv < fall_threshold) begin
        above_flag <= 1'b0;
      end
    end else if (cmd.finish) begin
      held_rate <= div_rate;
    end
  end

  // restoring divide of the fixed numerator by the beat interval
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      divisor <= interval[DIV_BITS-1:0];
      rem     <= '0;
      quo     <= RATE_NUMERATOR;
    end else if (cmd.div_step) begin
      if (!diff[DIV_BITS]) begin
        rem <= diff[DIV_BITS-1:0];
        quo <= {quo[DIV_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_BITS-1:0];
        quo <= {quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (direct_load || cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (direct_load) begin
      result.rate_bpm  <= fire ? '0 : held_rate;
      result.beat_seen <= fire;
    end else if (cmd.finish) begin
      result.rate_bpm  <= div_rate;
      result.beat_seen <= 1'b1;
    end
  end

endmodule

>>> design/heartbeat_rate_detector_core.sv
// Pulse-rate detector: each sample beat (millivolt level and millisecond
// stamp) yields one result beat with the rate in beats per minute and a
// flag for a detected beat edge. A sample that registers no beat, or a beat
// whose interval falls outside the configured limits, has its result in the
// cycle after acceptance. A beat with a valid interval goes through accept,
// 16 steps of the restoring divider that forms 60000 / interval one
// quotient bit per cycle, and a last step to saturate and load the
// result register. The output register decouples the two sides, so a new
// sample is taken while the previous result is being taken downstream.
// Configuration writes are always ready and should be issued while idle.
module heartbeat_rate_detector_core import hrd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  sample_t                   sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  hrd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  hrd_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

>>> design/hrd_checker.sv
module hrd_checker import hrd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // an accepted sample either yields a result next cycle or keeps input stalled
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> result_valid || sample_stall)
    else $error("accepted sample neither answered nor divider busy");

  // a taken result with no new sample leaves the output empty
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !(sample_valid && !sample_stall) |=> !result_valid)
    else $error("result beat repeated");

  // a beat-free result never follows directly from a stalled input
  assert property (@(posedge clk) disable iff (rst)
    sample_stall && !result_valid |=> !result_valid || result.beat_seen)
    else $error("result without beat appeared while busy");

endmodule

bind heartbeat_rate_detector_core hrd_checker u_hrd_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
